// File: rtl/core/itr_pkg.sv
// Shared types, codes and helpers for the infix-to-RPN converter.
package itr_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int OPK_W   = 3;
	localparam int CODE_W  = 8;
	localparam int VALUE_W = 64;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;

	// token kinds on the input
	localparam logic [CMD_W-1:0] CMD_OPERAND  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FUNCTION = 3'd1;
	localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LPAREN   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RPAREN   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_END      = 3'd5;

	// operator kinds
	localparam logic [OPK_W-1:0] OPK_PLUS  = 3'd0;
	localparam logic [OPK_W-1:0] OPK_MINUS = 3'd1;
	localparam logic [OPK_W-1:0] OPK_MULT  = 3'd2;
	localparam logic [OPK_W-1:0] OPK_DIV   = 3'd3;
	localparam logic [OPK_W-1:0] OPK_MOD   = 3'd4;
	localparam logic [OPK_W-1:0] OPK_EXP   = 3'd5;
	localparam logic [OPK_W-1:0] OPK_NONE  = 3'd0;

	// stack entry kinds, shared with the output kinds for function/operator
	localparam logic [KIND_W-1:0] ENT_FN = 2'd1;
	localparam logic [KIND_W-1:0] ENT_OP = 2'd2;
	localparam logic [KIND_W-1:0] ENT_LP = 2'd3;

	localparam logic [KIND_W-1:0] OUT_OPERAND = 2'd0;
	localparam logic [KIND_W-1:0] OUT_END     = 2'd3;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_RPAREN   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_LPAREN   = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [OPK_W-1:0]  opk;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [OPK_W-1:0]   op_kind;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic [ERR_W-1:0]   error;
	} res_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [OPK_W-1:0]   opk;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
	} tok_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORK,
		S_FNCHK,
		S_DONE
	} state_t;

	function automatic logic [1:0] prec_of(input logic [OPK_W-1:0] opk);
		logic [1:0] p;
		unique case (opk)
			OPK_EXP:                     p = 2'd3;
			OPK_MULT, OPK_DIV, OPK_MOD:  p = 2'd2;
			OPK_PLUS, OPK_MINUS:         p = 2'd1;
			default:                     p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic res_t entry_res(input entry_t e);
		res_t r;
		r.kind    = e.kind;
		r.op_kind = (e.kind == ENT_OP) ? e.opk : OPK_NONE;
		r.code    = e.code;
		r.value   = '0;
		r.error   = ERR_NONE;
		return r;
	endfunction

endpackage

// File: rtl/core/itr_tok_if.sv
// Token input channel: valid/ready handshake with the classified infix token.
interface itr_tok_if
	import itr_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [OPK_W-1:0]   op_kind;
	logic [CODE_W-1:0]  token_code;
	logic [VALUE_W-1:0] token_value;

	modport source (output valid, cmd, op_kind, token_code, token_value, input ready);
	modport sink   (input valid, cmd, op_kind, token_code, token_value, output ready);
endinterface

// File: rtl/core/itr_res_if.sv
// Result output channel: valid/ready handshake with one RPN item.
interface itr_res_if
	import itr_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  out_kind;
	logic [OPK_W-1:0]   out_op_kind;
	logic [CODE_W-1:0]  out_code;
	logic [VALUE_W-1:0] out_value;
	logic [ERR_W-1:0]   out_error;
	logic               out_last;

	modport source (output valid, out_kind, out_op_kind, out_code, out_value, out_error,
		out_last, input ready);
	modport sink   (input valid, out_kind, out_op_kind, out_code, out_value, out_error,
		out_last, output ready);
endinterface

// File: rtl/core/infix_to_rpn_converter.sv
// Shunting-yard infix-to-RPN converter with the operator stack in a synchronous RAM.
//
//  channel   dir  payload                                               accept
//  tokens    in   cmd, op_kind, token_code, token_value                 valid && ready
//  results   out  out_kind, out_op_kind, out_code, out_value,           valid && ready
//                 out_error, out_last
//
// A push token is pushed in S_WORK; each entry popped in a pop loop adds an S_WORK
// step, since the RAM read port always holds the top of stack for the next count. A
// right paren that meets its left paren adds an S_FNCHK step to check for (and pop) a
// function beneath it. An item that gives results adds a closing S_DONE step that
// sends the held result with out_last set. Reset clears the stack count and error at
// once. A stalled output stops the pop loop; tokens are taken only between items.
module infix_to_rpn_converter
	import itr_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	itr_tok_if.sink    tokens,
	itr_res_if.source  results
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// stack RAM
	entry_t          mem [STACK_DEPTH];
	entry_t          rdata_q;
	entry_t          fwd_data_q;
	logic            fwd_q;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	entry_t          wdata;
	entry_t          top;

	state_t          state_q, state_d;
	tok_t            tok_q;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [ERR_W-1:0] err_q, err_d;

	res_t            pend_q;
	logic            pend_v_q, pend_v_d;
	res_t            out_res_q;
	logic            out_last_q;
	logic            out_v_q;

	logic            accept;
	logic            slot_free;
	logic            can_go;
	logic            empty;
	logic            full;
	logic            err_set;
	logic            pop_op;
	logic            end_pop;
	logic            fn_pop;
	logic [ERR_W-1:0] end_err;

	logic            gen;
	logic            go;
	res_t            gen_res;
	logic            out_load;
	res_t            out_res_d;
	logic            out_last_d;

	assign top       = fwd_q ? fwd_data_q : rdata_q;
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign err_set   = (err_q != ERR_NONE);
	assign slot_free = !out_v_q || results.ready;
	assign can_go    = !pend_v_q || slot_free;
	assign accept    = tokens.valid && tokens.ready;

	assign pop_op  = !empty && (top.kind == ENT_OP) &&
		((prec_of(top.opk) > prec_of(tok_q.opk)) ||
		 ((prec_of(top.opk) == prec_of(tok_q.opk)) && (tok_q.opk != OPK_EXP)));
	assign end_pop = !err_set && !empty && (top.kind != ENT_LP);
	assign fn_pop  = !empty && (top.kind == ENT_FN);
	assign end_err = err_set ? err_q : (empty ? ERR_NONE : ERR_LPAREN);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_WORK;
				end
			end
			S_WORK: begin
				if (tok_q.cmd == CMD_END) begin
					if (can_go) begin
						state_d = end_pop ? S_WORK : S_DONE;
					end
				end else if (err_set) begin
					state_d = S_IDLE;
				end else begin
					unique case (tok_q.cmd)
						CMD_OPERAND: begin
							if (can_go) begin
								state_d = S_DONE;
							end
						end
						CMD_FUNCTION, CMD_LPAREN: state_d = S_IDLE;
						CMD_OPERATOR: begin
							if (!pop_op) begin
								state_d = pend_v_q ? S_DONE : S_IDLE;
							end
						end
						CMD_RPAREN: begin
							if (empty) begin
								state_d = pend_v_q ? S_DONE : S_IDLE;
							end else if (top.kind == ENT_LP) begin
								state_d = S_FNCHK;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FNCHK: begin
				if (fn_pop) begin
					if (can_go) begin
						state_d = S_DONE;
					end
				end else begin
					state_d = pend_v_q ? S_DONE : S_IDLE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// stack, error and result control
	always_comb begin
		logic push;
		logic pop;
		logic clr;
		logic set_err;
		logic [ERR_W-1:0] err_val;

		push    = 1'b0;
		pop     = 1'b0;
		clr     = 1'b0;
		set_err = 1'b0;
		err_val = ERR_NONE;
		gen     = 1'b0;
		gen_res = entry_res(top);
		wdata   = '{code: tok_q.code, opk: tok_q.opk, kind: ENT_FN};

		unique case (state_q)
			S_WORK: begin
				if (tok_q.cmd == CMD_END) begin
					gen = 1'b1;
					if (end_pop) begin
						pop = 1'b1;
					end else begin
						gen_res = '{kind: OUT_END, op_kind: OPK_NONE, code: '0, value: '0,
							error: end_err};
						clr = 1'b1;
					end
				end else if (!err_set) begin
					unique case (tok_q.cmd)
						CMD_OPERAND: begin
							gen = 1'b1;
							gen_res = '{kind: OUT_OPERAND, op_kind: OPK_NONE,
								code: tok_q.code, value: tok_q.value, error: ERR_NONE};
						end
						CMD_FUNCTION: push = 1'b1;
						CMD_LPAREN: begin
							push = 1'b1;
							wdata.kind = ENT_LP;
						end
						CMD_OPERATOR: begin
							wdata.kind = ENT_OP;
							if (pop_op) begin
								gen = 1'b1;
								pop = 1'b1;
							end else begin
								push = 1'b1;
							end
						end
						CMD_RPAREN: begin
							if (empty) begin
								set_err = 1'b1;
								err_val = ERR_RPAREN;
							end else if (top.kind == ENT_LP) begin
								pop = 1'b1;
							end else begin
								gen = 1'b1;
								pop = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_FNCHK: begin
				if (fn_pop) begin
					gen = 1'b1;
					pop = 1'b1;
				end
			end
			S_IDLE, S_DONE: ;
			default: ;
		endcase

		go = !gen || can_go;

		cnt_d = cnt_q;
		err_d = err_q;
		we    = 1'b0;
		if (go) begin
			if (clr) begin
				cnt_d = '0;
				err_d = ERR_NONE;
			end else if (set_err) begin
				cnt_d = '0;
				err_d = err_val;
			end else if (pop) begin
				cnt_d = cnt_q - CW'(1);
			end else if (push) begin
				if (full) begin
					cnt_d = '0;
					err_d = ERR_OVERFLOW;
				end else begin
					we    = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end
			end
		end

		// held result moves out when a newer one arrives or the item finishes
		pend_v_d   = pend_v_q;
		out_load   = 1'b0;
		out_res_d  = pend_q;
		out_last_d = 1'b0;
		if (gen && go) begin
			pend_v_d = 1'b1;
			out_load = pend_v_q;
		end else if (state_q == S_DONE && slot_free) begin
			pend_v_d   = 1'b0;
			out_load   = 1'b1;
			out_last_d = 1'b1;
		end
	end

	assign waddr = cnt_q[AW-1:0];
	assign raddr = AW'(cnt_d - CW'(1));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
		if (accept) begin
			tok_q <= '{cmd: tokens.cmd, opk: tokens.op_kind, code: tokens.token_code,
				value: tokens.token_value};
		end
		if (gen && go) begin
			pend_q <= gen_res;
		end
		if (out_load) begin
			out_res_q  <= out_res_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			err_q    <= ERR_NONE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			err_q    <= err_d;
			pend_v_q <= pend_v_d;
			fwd_q    <= we && (waddr == raddr);
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign tokens.ready        = (state_q == S_IDLE);
	assign results.valid       = out_v_q;
	assign results.out_kind    = out_res_q.kind;
	assign results.out_op_kind = out_res_q.op_kind;
	assign results.out_code    = out_res_q.code;
	assign results.out_value   = out_res_q.value;
	assign results.out_error   = out_res_q.error;
	assign results.out_last    = out_last_q;

endmodule

// File: test/itr_rpn_checker.sv
// Checker for the infix-to-RPN converter: predicts RPN output and compares it with the result channel.
`timescale 1ns / 1ps

module itr_rpn_checker
	import itr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	itr_tok_if   tokens,
	itr_res_if   results,
	output int   mismatches,
	output int   pending
);

	localparam int SW = $clog2(STACK_DEPTH_DEF);

	typedef struct packed {
		res_t res;
		logic last;
	} rpn_item_t;

	entry_t           shadow_stack [STACK_DEPTH_DEF];
	int               stack_fill = 0;
	logic [ERR_W-1:0] held_err = ERR_NONE;
	rpn_item_t        rpn_expect [$];
	int               fail_total = 0;

	function automatic logic [1:0] op_rank(input logic [OPK_W-1:0] k);
		case (k)
			OPK_EXP:                    return 2'd3;
			OPK_MULT, OPK_DIV, OPK_MOD: return 2'd2;
			OPK_PLUS, OPK_MINUS:        return 2'd1;
			default:                    return 2'd0;
		endcase
	endfunction

	function automatic res_t popped(input entry_t e);
		res_t r;
		r = '0;
		r.kind = e.kind;
		r.code = e.code;
		if (e.kind == ENT_OP)
			r.op_kind = e.opk;
		return r;
	endfunction

	// a push onto a full stack latches overflow and drops the stack
	function automatic void stack_push(input entry_t e);
		if (stack_fill >= STACK_DEPTH_DEF) begin
			held_err = ERR_OVERFLOW;
			stack_fill = 0;
		end else begin
			shadow_stack[SW'(stack_fill)] = e;
			stack_fill++;
		end
	endfunction

	function automatic void predict_token(input tok_t t);
		res_t             emitted [$];
		res_t             r;
		entry_t           e;
		entry_t           top;
		logic             found;
		logic             pops_equal;
		logic [1:0]       rank;
		logic [ERR_W-1:0] end_err;
		rpn_item_t        item;
		e.code = t.code;
		e.opk = t.opk;
		e.kind = ENT_FN;
		r = '0;
		found = 1'b0;
		if (t.cmd == CMD_END) begin
			end_err = held_err;
			if (end_err == ERR_NONE) begin
				while (stack_fill > 0) begin
					top = shadow_stack[SW'(stack_fill - 1)];
					if (top.kind == ENT_LP) begin
						end_err = ERR_LPAREN;
						break;
					end
					stack_fill--;
					emitted.push_back(popped(top));
				end
			end
			r.kind = OUT_END;
			r.error = end_err;
			emitted.push_back(r);
			stack_fill = 0;
			held_err = ERR_NONE;
		end else if (held_err == ERR_NONE) begin
			case (t.cmd)
				CMD_OPERAND: begin
					r.kind = OUT_OPERAND;
					r.code = t.code;
					r.value = t.value;
					emitted.push_back(r);
				end
				CMD_FUNCTION: stack_push(e);
				CMD_OPERATOR: begin
					rank = op_rank(t.opk);
					pops_equal = (t.opk != OPK_EXP);
					// only operators are popped; a paren or function stops the scan
					while (stack_fill > 0) begin
						top = shadow_stack[SW'(stack_fill - 1)];
						if (top.kind != ENT_OP)
							break;
						if (!(op_rank(top.opk) > rank || (op_rank(top.opk) == rank && pops_equal)))
							break;
						stack_fill--;
						emitted.push_back(popped(top));
					end
					e.kind = ENT_OP;
					stack_push(e);
				end
				CMD_LPAREN: begin
					e.kind = ENT_LP;
					stack_push(e);
				end
				CMD_RPAREN: begin
					while (stack_fill > 0 && !found) begin
						top = shadow_stack[SW'(stack_fill - 1)];
						stack_fill--;
						if (top.kind == ENT_LP)
							found = 1'b1;
						else
							emitted.push_back(popped(top));
					end
					if (!found) begin
						held_err = ERR_RPAREN;
						stack_fill = 0;
					end else if (stack_fill > 0 &&
						shadow_stack[SW'(stack_fill - 1)].kind == ENT_FN) begin
						stack_fill--;
						emitted.push_back(popped(shadow_stack[SW'(stack_fill)]));
					end
				end
				default: ;
			endcase
		end
		foreach (emitted[i]) begin
			item.res = emitted[i];
			item.last = (i == emitted.size() - 1);
			rpn_expect.push_back(item);
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpn_item_t want;
		tok_t      taken;
		if (!arst_n) begin
			stack_fill = 0;
			held_err = ERR_NONE;
			rpn_expect.delete();
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (rpn_expect.size() == 0) begin
					$error("result with nothing expected: out_kind %0d, out_code 0x%0h",
						results.out_kind, results.out_code);
					fail_total++;
				end else begin
					want = rpn_expect.pop_front();
					check_field("out_kind", 64'(want.res.kind), 64'(results.out_kind));
					check_field("out_op_kind", 64'(want.res.op_kind),
						64'(results.out_op_kind));
					check_field("out_code", 64'(want.res.code), 64'(results.out_code));
					check_field("out_value", want.res.value, results.out_value);
					check_field("out_error", 64'(want.res.error), 64'(results.out_error));
					check_field("out_last", 64'(want.last), 64'(results.out_last));
				end
			end
			if (tokens.valid && tokens.ready) begin
				taken.cmd = tokens.cmd;
				taken.opk = tokens.op_kind;
				taken.code = tokens.token_code;
				taken.value = tokens.token_value;
				predict_token(taken);
			end
			pending <= rpn_expect.size();
			mismatches <= fail_total;
		end
	end

endmodule

// File: test/infix_to_rpn_converter_tb.sv
// Testbench top for the infix-to-RPN converter: clock, reset, token stimulus and verdict.
`timescale 1ns / 1ps

module infix_to_rpn_converter_tb
	import itr_pkg::*;
;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam logic [OPK_W-1:0] OPK_SPARE_A = 3'd6;
	localparam logic [OPK_W-1:0] OPK_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 165;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_NEST     = 4;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   gap_pct = 7;
	int   stall_pct = 63;
	int   sent = 0;
	int   quiet = 0;
	tok_t token_seq [$];

	itr_tok_if tokens ();
	itr_res_if results ();

	infix_to_rpn_converter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (tokens),
		.results (results)
	);

	itr_rpn_checker rpn_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.tokens     (tokens),
		.results    (results),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			results.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tokens.valid && tokens.ready) || (results.valid && results.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [OPK_W-1:0] pick_op();
		if ($urandom_range(15) == 0)
			return $urandom_range(1) ? OPK_SPARE_A : OPK_SPARE_B;
		return OPK_W'($urandom_range(OPK_EXP));
	endfunction

	function automatic void add_fixed(input logic [CMD_W-1:0] cmd, input logic [OPK_W-1:0] opk,
		input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value);
		tok_t t;
		t.cmd = cmd;
		t.opk = opk;
		t.code = code;
		t.value = value;
		token_seq.push_back(t);
	endfunction

	function automatic void add_tok(input logic [CMD_W-1:0] cmd, input logic [OPK_W-1:0] opk);
		add_fixed(cmd, opk, CODE_W'($urandom), {$urandom, $urandom});
	endfunction

	function automatic logic [OPK_W-1:0] any_opk();
		return OPK_W'($urandom_range(7));
	endfunction

	// well-formed expression, parens nested up to MAX_NEST
	function automatic void build_expr();
		int n_opnd;
		int nest;
		int i;
		n_opnd = $urandom_range(1, 7);
		nest = 0;
		for (i = 0; i < n_opnd; i++) begin
			if (i > 0)
				add_tok(CMD_OPERATOR, pick_op());
			while (nest < MAX_NEST && $urandom_range(2) == 0) begin
				if ($urandom_range(2) == 0)
					add_tok(CMD_FUNCTION, any_opk());
				add_tok(CMD_LPAREN, any_opk());
				nest++;
			end
			add_tok(CMD_OPERAND, any_opk());
			while (nest > 0 && (i == n_opnd - 1 || $urandom_range(1) == 0)) begin
				add_tok(CMD_RPAREN, any_opk());
				nest--;
			end
		end
	endfunction

	function automatic void build_nest(input int levels);
		repeat (levels) begin
			if ($urandom_range(3) == 0)
				add_tok(CMD_FUNCTION, any_opk());
			add_tok(CMD_LPAREN, any_opk());
		end
		add_tok(CMD_OPERAND, any_opk());
		repeat (levels) add_tok(CMD_RPAREN, any_opk());
	endfunction

	// right-associative chain keeps every exp on the stack
	function automatic void build_exp_chain(input int n);
		add_tok(CMD_OPERAND, any_opk());
		repeat (n) begin
			add_tok(CMD_OPERATOR, OPK_EXP);
			add_tok(CMD_OPERAND, any_opk());
		end
	endfunction

	task automatic send_token(input tok_t t);
		while ($urandom_range(99) < gap_pct) begin
			tokens.valid <= 1'b0;
			@(posedge clk);
		end
		tokens.valid <= 1'b1;
		tokens.cmd <= t.cmd;
		tokens.op_kind <= t.opk;
		tokens.token_code <= t.code;
		tokens.token_value <= t.value;
		do @(posedge clk); while (!tokens.ready);
		if (t.cmd != CMD_SPARE_A && t.cmd != CMD_SPARE_B)
			sent++;
	endtask

	task automatic send_seq();
		foreach (token_seq[i]) send_token(token_seq[i]);
		token_seq.delete();
	endtask

	task automatic wait_drained();
		tokens.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int   phase;
		int   roll;
		int   pos;
		int   start;
		tok_t stray;
		arst_n = 1'b0;
		tokens.valid = 1'b0;
		tokens.cmd = CMD_OPERAND;
		tokens.op_kind = OPK_PLUS;
		tokens.token_code = '0;
		tokens.token_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fn ( a + b * c / d % e ^ f ^ g - h ) end, field extremes on the ends
		add_fixed(CMD_FUNCTION, OPK_EXP, 8'hFF, '1);
		add_tok(CMD_LPAREN, OPK_MULT);
		add_fixed(CMD_OPERAND, OPK_PLUS, 8'h00, 64'h0);
		add_tok(CMD_OPERATOR, OPK_PLUS);
		add_fixed(CMD_OPERAND, OPK_SPARE_B, 8'hFF, '1);
		add_tok(CMD_OPERATOR, OPK_MULT);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_DIV);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_MOD);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_EXP);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_EXP);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_MINUS);
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_RPAREN, any_opk());
		add_fixed(CMD_END, OPK_SPARE_B, 8'hFF, '1);
		// unknown operator kinds, then an unknown token kind
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_OPERATOR, OPK_SPARE_A);
		add_tok(CMD_OPERATOR, OPK_SPARE_B);
		add_tok(CMD_SPARE_A, any_opk());
		add_tok(CMD_END, any_opk());
		// unmatched right paren, then unmatched left paren
		add_tok(CMD_RPAREN, any_opk());
		add_tok(CMD_END, any_opk());
		add_tok(CMD_LPAREN, any_opk());
		add_tok(CMD_OPERAND, any_opk());
		add_tok(CMD_END, any_opk());
		send_seq();

		// guaranteed overflow before the random mix
		build_nest(33);
		add_tok(CMD_END, any_opk());
		send_seq();

		phase = 0;
		start = sent;
		while (sent < start + RANDOM_ITEMS) begin
			if (phase < 2 && sent - start >= (phase + 1) * RANDOM_ITEMS / 3) begin
				wait_drained();
				phase++;
				if (phase == 1) begin
					gap_pct = 63;
					stall_pct = 7;
				end else begin
					gap_pct = 0;
					stall_pct = 0;
				end
			end
			roll = $urandom_range(99);
			if (roll < 58) begin
				build_expr();
			end else if (roll < 66) begin
				build_nest($urandom_range(8, 36));
			end else if (roll < 72) begin
				build_exp_chain($urandom_range(8, 36));
			end else if (roll < 86) begin
				// broken expression: one token dropped or a stray paren added
				build_expr();
				pos = $urandom_range(token_seq.size() - 1);
				if ($urandom_range(1)) begin
					token_seq.delete(pos);
				end else begin
					stray.cmd = $urandom_range(1) ? CMD_LPAREN : CMD_RPAREN;
					stray.opk = any_opk();
					stray.code = CODE_W'($urandom);
					stray.value = {$urandom, $urandom};
					token_seq.insert(pos, stray);
				end
			end else begin
				repeat ($urandom_range(2, 10)) add_tok(CMD_W'($urandom_range(7)), any_opk());
			end
			add_tok(CMD_END, any_opk());
			send_seq();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
